/* rtl/core/source_tokenizer_top_assert.svh */
// assertion macros shared by the tokenizer modules
// each macro expects clk and rst_n in scope
`ifndef SOURCE_TOKENIZER_TOP_ASSERT_SVH
`define SOURCE_TOKENIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define STK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define STK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`define STK_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define STK_ASSERT_IMP(lbl, ante, cons, msg)

`define STK_ASSERT_NEXT(lbl, ante, cons, msg)

`define STK_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

/* rtl/core/stk_pkg.sv */
package stk_pkg;

  localparam int POS_WIDTH_DEF     = 16;
  localparam int KEYWORD_CHARS_DEF = 7;
  localparam int OQ_DEPTH          = 4;
  localparam int KW_NUM            = 11;
  localparam logic [15:0] LEN_MAX  = 16'hFFFF;

  // token kinds
  localparam logic [5:0] K_IDENT      = 6'd0;
  localparam logic [5:0] K_NUMBER     = 6'd1;
  localparam logic [5:0] K_STRING     = 6'd2;
  localparam logic [5:0] K_NEWLINE    = 6'd3;
  localparam logic [5:0] K_ASSIGN     = 6'd4;
  localparam logic [5:0] K_ANNOTATE   = 6'd5;
  localparam logic [5:0] K_EQ         = 6'd6;
  localparam logic [5:0] K_NOTEQ      = 6'd7;
  localparam logic [5:0] K_NOT        = 6'd8;
  localparam logic [5:0] K_GE         = 6'd9;
  localparam logic [5:0] K_GT         = 6'd10;
  localparam logic [5:0] K_LE         = 6'd11;
  localparam logic [5:0] K_LT         = 6'd12;
  localparam logic [5:0] K_ARROW      = 6'd13;
  localparam logic [5:0] K_MINUS      = 6'd14;
  localparam logic [5:0] K_PLUS       = 6'd15;
  localparam logic [5:0] K_SLASH      = 6'd16;
  localparam logic [5:0] K_STAR       = 6'd17;
  localparam logic [5:0] K_AND        = 6'd18;
  localparam logic [5:0] K_OR         = 6'd19;
  localparam logic [5:0] K_LBRACE     = 6'd20;
  localparam logic [5:0] K_RBRACE     = 6'd21;
  localparam logic [5:0] K_LPAREN     = 6'd22;
  localparam logic [5:0] K_RPAREN     = 6'd23;
  localparam logic [5:0] K_LSQ        = 6'd24;
  localparam logic [5:0] K_RSQ        = 6'd25;
  localparam logic [5:0] K_DOT        = 6'd26;
  localparam logic [5:0] K_COMMA      = 6'd27;
  localparam logic [5:0] K_SEMI       = 6'd28;
  localparam logic [5:0] K_KEYWORD0   = 6'd29;
  localparam logic [5:0] K_ERR_STRING = 6'd40;
  localparam logic [5:0] K_ERR_CHAR   = 6'd41;

  // keyword text, packed first character highest
  localparam logic [63:0] KW_PACK [KW_NUM] = '{
    64'h666E,             // fn
    64'h72657475726E,     // return
    64'h7072696E74,       // print
    64'h6966,             // if
    64'h656C7365,         // else
    64'h7768696C65,       // while
    64'h666F72,           // for
    64'h74727565,         // true
    64'h66616C7365,       // false
    64'h6E696C,           // nil
    64'h74797065646566    // typedef
  };
  localparam logic [15:0] KW_LEN [KW_NUM] = '{
    16'd2, 16'd6, 16'd5, 16'd2, 16'd4, 16'd5, 16'd3, 16'd4, 16'd5, 16'd3, 16'd7
  };

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_STRING, MODE_COLON,
    MODE_QUEST, MODE_BANG, MODE_GT, MODE_LT, MODE_MINUS
  } stk_mode_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } stk_in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] start_pos;
    logic [15:0] token_length;
    logic        is_negative;
    logic        run_end;
  } stk_out_t;

  // results of one item on their way into the output queue
  typedef struct packed {
    logic [1:0] n;
    stk_out_t   tok0;
    stk_out_t   tok1;
  } stk_push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return (c == "'") || (c == "\"");
  endfunction

  function automatic logic [15:0] len_inc(input logic [15:0] v);
    return (v == LEN_MAX) ? LEN_MAX : v + 16'd1;
  endfunction

  function automatic stk_out_t mk_tok(input logic [5:0] kind, input logic [15:0] start,
                                      input logic [15:0] len, input logic neg);
    stk_out_t t;
    t.token_kind   = kind;
    t.start_pos    = start;
    t.token_length = len;
    t.is_negative  = neg;
    t.run_end      = 1'b0;
    return t;
  endfunction

  // whole-word keyword match, identifier otherwise
  function automatic logic [5:0] word_kind(input logic [15:0] cnt, input logic [63:0] prefix);
    logic [5:0] kind;
    kind = K_IDENT;
    for (int k = 0; k < KW_NUM; k++) begin
      if (cnt == KW_LEN[k] && prefix == KW_PACK[k]) begin
        kind = K_KEYWORD0 + 6'(k);
      end
    end
    return kind;
  endfunction

endpackage

/* rtl/core/stk_scan.sv */
`include "source_tokenizer_top_assert.svh"

module stk_scan #(
  parameter int POS_WIDTH     = stk_pkg::POS_WIDTH_DEF,
  parameter int KEYWORD_CHARS = stk_pkg::KEYWORD_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  stk_pkg::stk_in_t   in_item,
  output stk_pkg::stk_push_t push
);

  localparam int PFX_W = 8 * KEYWORD_CHARS;

  stk_pkg::stk_mode_t mode_r, mode_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [POS_WIDTH-1:0] ts_r, ts_nxt;
  logic [15:0]          tc_r, tc_nxt;
  logic [PFX_W-1:0]     wp_r, wp_nxt;
  logic                 ms_r, ms_nxt;
  logic                 halt_r, halt_nxt;

  logic [7:0] c;
  logic       last;
  logic       consumed;
  logic       r_v, b_v, f_v;
  stk_pkg::stk_out_t r_tok, b_tok, f_tok;

  assign c    = in_item.char_code;
  assign last = in_item.end_of_text;

  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    ts_nxt   = ts_r;
    tc_nxt   = tc_r;
    wp_nxt   = wp_r;
    ms_nxt   = ms_r;
    halt_nxt = halt_r;
    consumed = 1'b0;
    r_v      = 1'b0;
    b_v      = 1'b0;
    f_v      = 1'b0;
    r_tok    = '0;
    b_tok    = '0;
    f_tok    = '0;

    if (!halt_r) begin
      // settle the pending token with this byte
      case (mode_r)
        stk_pkg::MODE_STRING: begin
          consumed = 1'b1;
          if (stk_pkg::is_quote(c)) begin
            r_v      = 1'b1;
            r_tok    = stk_pkg::mk_tok(stk_pkg::K_STRING, 16'(ts_r), tc_r, 1'b0);
            mode_nxt = stk_pkg::MODE_IDLE;
          end else begin
            tc_nxt = stk_pkg::len_inc(tc_r);
          end
        end
        stk_pkg::MODE_IDENT: begin
          if (stk_pkg::is_alpha(c) || stk_pkg::is_digit(c)) begin
            consumed = 1'b1;
            wp_nxt   = {wp_r[PFX_W-9:0], c};
            tc_nxt   = stk_pkg::len_inc(tc_r);
          end else begin
            r_v      = 1'b1;
            r_tok    = stk_pkg::mk_tok(stk_pkg::word_kind(tc_r, 64'(wp_r)), 16'(ts_r),
                                       tc_r, 1'b0);
            mode_nxt = stk_pkg::MODE_IDLE;
          end
        end
        stk_pkg::MODE_NUMBER: begin
          if (stk_pkg::is_digit(c) || c == ".") begin
            consumed = 1'b1;
            tc_nxt   = stk_pkg::len_inc(tc_r);
          end else begin
            r_v      = 1'b1;
            r_tok    = stk_pkg::mk_tok(stk_pkg::K_NUMBER, 16'(ts_r), tc_r, ms_r);
            mode_nxt = stk_pkg::MODE_IDLE;
          end
        end
        stk_pkg::MODE_COLON: begin
          r_v      = 1'b1;
          consumed = (c == "=");
          r_tok    = consumed ? stk_pkg::mk_tok(stk_pkg::K_ASSIGN, 16'(ts_r), 16'd2, 1'b0)
                              : stk_pkg::mk_tok(stk_pkg::K_ANNOTATE, 16'(ts_r), 16'd1, 1'b0);
          mode_nxt = stk_pkg::MODE_IDLE;
        end
        stk_pkg::MODE_QUEST: begin
          r_v      = 1'b1;
          consumed = 1'b1;
          mode_nxt = stk_pkg::MODE_IDLE;
          if (c == "=") begin
            r_tok = stk_pkg::mk_tok(stk_pkg::K_EQ, 16'(ts_r), 16'd2, 1'b0);
          end else begin
            r_tok    = stk_pkg::mk_tok(stk_pkg::K_ERR_CHAR, 16'(ts_r), 16'd1, 1'b0);
            halt_nxt = 1'b1;
          end
        end
        stk_pkg::MODE_BANG: begin
          r_v      = 1'b1;
          consumed = (c == "=");
          r_tok    = consumed ? stk_pkg::mk_tok(stk_pkg::K_NOTEQ, 16'(ts_r), 16'd2, 1'b0)
                              : stk_pkg::mk_tok(stk_pkg::K_NOT, 16'(ts_r), 16'd1, 1'b0);
          mode_nxt = stk_pkg::MODE_IDLE;
        end
        stk_pkg::MODE_GT: begin
          r_v      = 1'b1;
          consumed = (c == "=");
          r_tok    = consumed ? stk_pkg::mk_tok(stk_pkg::K_GE, 16'(ts_r), 16'd2, 1'b0)
                              : stk_pkg::mk_tok(stk_pkg::K_GT, 16'(ts_r), 16'd1, 1'b0);
          mode_nxt = stk_pkg::MODE_IDLE;
        end
        stk_pkg::MODE_LT: begin
          r_v      = 1'b1;
          consumed = (c == "=");
          r_tok    = consumed ? stk_pkg::mk_tok(stk_pkg::K_LE, 16'(ts_r), 16'd2, 1'b0)
                              : stk_pkg::mk_tok(stk_pkg::K_LT, 16'(ts_r), 16'd1, 1'b0);
          mode_nxt = stk_pkg::MODE_IDLE;
        end
        stk_pkg::MODE_MINUS: begin
          if (c == ">") begin
            consumed = 1'b1;
            r_v      = 1'b1;
            r_tok    = stk_pkg::mk_tok(stk_pkg::K_ARROW, 16'(ts_r), 16'd2, 1'b0);
            mode_nxt = stk_pkg::MODE_IDLE;
          end else if (stk_pkg::is_digit(c)) begin
            // negative number starts at the digit
            consumed = 1'b1;
            mode_nxt = stk_pkg::MODE_NUMBER;
            ms_nxt   = 1'b1;
            ts_nxt   = pos_r;
            tc_nxt   = 16'd1;
          end else begin
            r_v      = 1'b1;
            r_tok    = stk_pkg::mk_tok(stk_pkg::K_MINUS, 16'(ts_r), 16'd1, 1'b0);
            mode_nxt = stk_pkg::MODE_IDLE;
          end
        end
        default: begin
          mode_nxt = stk_pkg::MODE_IDLE;
        end
      endcase

      // byte not taken by the pending token starts a new one
      if (!consumed && !halt_nxt) begin
        ts_nxt = pos_r;
        b_tok  = stk_pkg::mk_tok(stk_pkg::K_PLUS, 16'(pos_r), 16'd1, 1'b0);
        case (c)
          " ":  ;
          "\n": begin
            b_v = 1'b1;
            b_tok.token_kind = stk_pkg::K_NEWLINE;
          end
          ":": mode_nxt = stk_pkg::MODE_COLON;
          "?": mode_nxt = stk_pkg::MODE_QUEST;
          "!": mode_nxt = stk_pkg::MODE_BANG;
          ">": mode_nxt = stk_pkg::MODE_GT;
          "<": mode_nxt = stk_pkg::MODE_LT;
          "-": mode_nxt = stk_pkg::MODE_MINUS;
          "+": b_v = 1'b1;
          "/": begin b_v = 1'b1; b_tok.token_kind = stk_pkg::K_SLASH;  end
          "*": begin b_v = 1'b1; b_tok.token_kind = stk_pkg::K_STAR;   end
          "&": begin b_v = 1'b1; b_tok.token_kind = stk_pkg::K_AND;    end
          "|": begin b_v = 1'b1; b_tok.token_kind = stk_pkg::K_OR;     end
          "{": begin b_v = 1'b1; b_tok.token_kind = stk_pkg::K_LBRACE; end
          "}": begin b_v = 1'b1; b_tok.token_kind = stk_pkg::K_RBRACE; end
          "(": begin b_v = 1'b1; b_tok.token_kind = stk_pkg::K_LPAREN; end
          ")": begin b_v = 1'b1; b_tok.token_kind = stk_pkg::K_RPAREN; end
          "[": begin b_v = 1'b1; b_tok.token_kind = stk_pkg::K_LSQ;    end
          "]": begin b_v = 1'b1; b_tok.token_kind = stk_pkg::K_RSQ;    end
          ".": begin b_v = 1'b1; b_tok.token_kind = stk_pkg::K_DOT;    end
          ",": begin b_v = 1'b1; b_tok.token_kind = stk_pkg::K_COMMA;  end
          ";": begin b_v = 1'b1; b_tok.token_kind = stk_pkg::K_SEMI;   end
          default: begin
            if (stk_pkg::is_quote(c)) begin
              mode_nxt = stk_pkg::MODE_STRING;
              tc_nxt   = 16'd0;
            end else if (stk_pkg::is_digit(c)) begin
              mode_nxt = stk_pkg::MODE_NUMBER;
              tc_nxt   = 16'd1;
              ms_nxt   = 1'b0;
            end else if (stk_pkg::is_alpha(c)) begin
              mode_nxt = stk_pkg::MODE_IDENT;
              tc_nxt   = 16'd1;
              wp_nxt   = PFX_W'(c);
            end else begin
              b_v              = 1'b1;
              b_tok.token_kind = stk_pkg::K_ERR_CHAR;
              halt_nxt         = 1'b1;
              mode_nxt         = stk_pkg::MODE_IDLE;
            end
          end
        endcase
      end

      // last byte flushes whatever is still pending
      if (last && !halt_nxt) begin
        f_v = 1'b1;
        case (mode_nxt)
          stk_pkg::MODE_STRING:
            f_tok = stk_pkg::mk_tok(stk_pkg::K_ERR_STRING, 16'(ts_nxt), tc_nxt, 1'b0);
          stk_pkg::MODE_IDENT:
            f_tok = stk_pkg::mk_tok(stk_pkg::word_kind(tc_nxt, 64'(wp_nxt)), 16'(ts_nxt),
                                    tc_nxt, 1'b0);
          stk_pkg::MODE_NUMBER:
            f_tok = stk_pkg::mk_tok(stk_pkg::K_NUMBER, 16'(ts_nxt), tc_nxt, ms_nxt);
          stk_pkg::MODE_COLON:
            f_tok = stk_pkg::mk_tok(stk_pkg::K_ANNOTATE, 16'(ts_nxt), 16'd1, 1'b0);
          stk_pkg::MODE_QUEST:
            f_tok = stk_pkg::mk_tok(stk_pkg::K_ERR_CHAR, 16'(ts_nxt), 16'd1, 1'b0);
          stk_pkg::MODE_BANG:
            f_tok = stk_pkg::mk_tok(stk_pkg::K_NOT, 16'(ts_nxt), 16'd1, 1'b0);
          stk_pkg::MODE_GT:
            f_tok = stk_pkg::mk_tok(stk_pkg::K_GT, 16'(ts_nxt), 16'd1, 1'b0);
          stk_pkg::MODE_LT:
            f_tok = stk_pkg::mk_tok(stk_pkg::K_LT, 16'(ts_nxt), 16'd1, 1'b0);
          stk_pkg::MODE_MINUS:
            f_tok = stk_pkg::mk_tok(stk_pkg::K_MINUS, 16'(ts_nxt), 16'd1, 1'b0);
          default:
            f_v = 1'b0;
        endcase
      end
    end

    if (last) begin
      mode_nxt = stk_pkg::MODE_IDLE;
      pos_nxt  = '0;
      ts_nxt   = '0;
      tc_nxt   = '0;
      wp_nxt   = '0;
      ms_nxt   = 1'b0;
      halt_nxt = 1'b0;
    end else if (pos_r != '1) begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  // order the results of this byte and flag the last one
  always_comb begin
    push.n    = 2'(r_v) + 2'(b_v) + 2'(f_v);
    push.tok0 = r_v ? r_tok : (b_v ? b_tok : f_tok);
    push.tok1 = (r_v && b_v) ? b_tok : f_tok;
    push.tok0.run_end = (push.n == 2'd1);
    push.tok1.run_end = 1'b1;
    if (!take) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stk_pkg::MODE_IDLE;
      pos_r  <= '0;
      ts_r   <= '0;
      tc_r   <= '0;
      wp_r   <= '0;
      ms_r   <= 1'b0;
      halt_r <= 1'b0;
    end else if (take) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      ts_r   <= ts_nxt;
      tc_r   <= tc_nxt;
      wp_r   <= wp_nxt;
      ms_r   <= ms_nxt;
      halt_r <= halt_nxt;
    end
  end

  `STK_ASSERT_IMP(a_halt_is_idle, halt_r, mode_r == stk_pkg::MODE_IDLE, "halted while a token is pending")
  `STK_ASSERT_NEXT(a_last_clears, take && last, pos_r == '0 && !halt_r && mode_r == stk_pkg::MODE_IDLE, "last byte did not restart the scan")
  `STK_ASSERT_NEXT(a_halt_holds, take && !last && halt_r, halt_r, "left the halted state before the last byte")

endmodule

/* rtl/core/stk_outq.sv */
`include "source_tokenizer_top_assert.svh"

module stk_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  stk_pkg::stk_push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output stk_pkg::stk_out_t  out_data
);

  localparam int PTR_W = $clog2(stk_pkg::OQ_DEPTH);
  localparam int CNT_W = $clog2(stk_pkg::OQ_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(stk_pkg::OQ_DEPTH);

  stk_pkg::stk_out_t mem_r [stk_pkg::OQ_DEPTH];
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_p1;

  // two free entries are kept so that a byte giving two tokens always fits
  assign room      = count_r <= (DEPTH_C - CNT_W'(2));
  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.n);
    count_nxt  = count_r + CNT_W'(push.n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.tok0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `STK_ASSERT_NEVER(a_no_overflow, CNT_W'(push.n) > (DEPTH_C - count_r), "result queue overflow")
  `STK_ASSERT_NEVER(a_count_bound, count_r > DEPTH_C, "result queue count out of range")
  `STK_ASSERT_IMP(a_ptr_match, 1'b1, wr_ptr_r == PTR_W'(rd_ptr_r + PTR_W'(count_r)), "queue pointers disagree with count")

endmodule

/* rtl/core/source_tokenizer_top.sv */
// source tokenizer: lexes a byte stream into tokens
// input channel in_valid/in_ready/in_data carries one source byte per item,
// with end_of_text marking the final byte of a text
// output channel out_valid/out_ready/out_data carries one token per item:
// kind, start position, length, negative flag and run_end on the last token
// that a byte produced (a byte produces zero, one or two tokens)
// each accepted byte is decoded in the cycle it is taken; its tokens sit in a
// four-entry result queue; the first is offered next cycle if it was empty
// throughput: one byte per cycle; the queue drains one token per cycle, so
// bytes are taken every cycle as long as tokens are drained as fast as made
// in_ready drops while fewer than two queue entries are free, which is how a
// stalled receiver holds back the input side without losing tokens
// reset (rst_n low, synchronous) empties the queue, clears the position and
// any pending token; an error token stops tokenizing until the last byte
module source_tokenizer_top #(
  parameter int POS_WIDTH     = stk_pkg::POS_WIDTH_DEF,
  parameter int KEYWORD_CHARS = stk_pkg::KEYWORD_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stk_pkg::stk_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output stk_pkg::stk_out_t out_data
);

  logic               take;
  stk_pkg::stk_push_t push;

  assign take = in_valid && in_ready;

  stk_scan #(
    .POS_WIDTH     (POS_WIDTH),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_item (in_data),
    .push    (push)
  );

  stk_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
